@@ design/radar_frame_deframer_assert.svh @@
// assertion macros shared by the deframer rtl
`ifndef RADAR_FRAME_DEFRAMER_ASSERT_SVH
`define RADAR_FRAME_DEFRAMER_ASSERT_SVH

`ifndef SYNTHESIS

// condition implies consequence in the same cycle
`define RFD_ASSERT_IMPL(label, clk, rstn, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (conseq)) \
        else $error("deframer assertion failed");

// condition implies consequence in the next cycle
`define RFD_ASSERT_NEXT(label, clk, rstn, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (conseq)) \
        else $error("deframer assertion failed");

`else

`define RFD_ASSERT_IMPL(label, clk, rstn, cond, conseq)
`define RFD_ASSERT_NEXT(label, clk, rstn, cond, conseq)

`endif

`endif

@@ design/rfd_pkg.sv @@
// types and constants shared by the deframer modules
`timescale 1ns / 1ps

package rfd_pkg;

    localparam int MAX_PAYLOAD  = 1024;
    localparam int HEADER_BYTES = 8;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);

    localparam logic [7:0]  START_BYTE_RESET = 8'h01;
    localparam logic [15:0] MAX_PAYLOAD_LEN  = 16'(MAX_PAYLOAD);
    localparam logic [10:0] HDR_LAST_POS     = 11'(HEADER_BYTES - 1);

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_HEADER  = 2'd1,
        PH_PAYLOAD = 2'd2,
        PH_CHECK   = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        EV_DROP     = 3'd0,
        EV_HEADER   = 3'd1,
        EV_PAYLOAD  = 3'd2,
        EV_GOOD     = 3'd3,
        EV_HDR_ERR  = 3'd4,
        EV_OVERSIZE = 3'd5,
        EV_DATA_ERR = 3'd6
    } event_t;

    // one classified byte on its way from parser to result stage
    typedef struct packed {
        event_t      ev;
        logic [7:0]  pbyte;
        logic [9:0]  pidx;
        logic [15:0] fid;
        logic [15:0] ftype;
        logic [10:0] plen;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

@@ design/radar_frame_deframer.sv @@
// top level of the serial frame deframer
`timescale 1ns / 1ps

// serial frame deframer. takes one received byte per item on s_ and gives one
// result item per byte on m_: dropped while hunting, header byte, payload byte
// with its index, frame good, header checksum error, oversize, or data
// checksum error. a frame is start byte, big-endian id, length and type,
// then the inverted xor of those seven bytes, then the payload and its own
// inverted xor checksum (0xff for an empty payload). on a data checksum error
// the consumer must throw away the payload bytes it already took. the header
// fields and the four wrapping 32-bit counters travel with every result as
// they stand after that byte. the parser takes one byte per clock while the
// queue has room; each result is registered in a four-item queue and then in
// the result register, so a stalled consumer holds the input off only once
// the queue is full. the start byte must be written through cfg_ (reset value
// 0x01) while the block is idle; the block itself does not enforce this.
module radar_frame_deframer import rfd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: start byte
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    // received bytes
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    // results
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_event_res,
    output logic [7:0]  m_payload_byte,
    output logic [9:0]  m_payload_index,
    output logic [15:0] m_frame_ident,
    output logic [15:0] m_frame_kind,
    output logic [10:0] m_payload_len,
    output logic [31:0] m_good_frames,
    output logic [31:0] m_header_errors,
    output logic [31:0] m_data_errors,
    output logic [31:0] m_oversize_errors
);

    q_status_t q_status;
    logic      push;
    logic      pop;
    item_t     push_item;
    item_t     pop_item;
    item_t     out_item;

    // parser: phase, position, running xor and header fields
    rfd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_in_byte (s_in_byte),
        .q_status  (q_status),
        .push      (push),
        .push_item (push_item)
    );

    // classified items wait here while the consumer stalls
    rfd_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .q_status  (q_status)
    );

    // counters and output register
    rfd_back u_back (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .q_status           (q_status),
        .pop_item           (pop_item),
        .pop                (pop),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .out_item           (out_item),
        .good_count         (m_good_frames),
        .header_error_count (m_header_errors),
        .data_error_count   (m_data_errors),
        .oversize_count     (m_oversize_errors)
    );

    assign m_event_res     = out_item.ev;
    assign m_payload_byte  = out_item.pbyte;
    assign m_payload_index = out_item.pidx;
    assign m_frame_ident   = out_item.fid;
    assign m_frame_kind    = out_item.ftype;
    assign m_payload_len   = out_item.plen;

endmodule

@@ design/rfd_front.sv @@
// byte parser: hunts for the start byte and classifies each received byte
`timescale 1ns / 1ps
`include "radar_frame_deframer_assert.svh"

module rfd_front import rfd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    input  q_status_t   q_status,
    output logic        push,
    output item_t       push_item
);

    phase_t      phase_reg, phase_next;
    logic [10:0] pos_reg, pos_next;
    logic [7:0]  xor_reg, xor_next;
    logic [15:0] id_reg, id_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] type_reg, type_next;
    logic [7:0]  start_reg;

    logic        accept;
    logic        hdr_last;
    logic        chk_ok;
    logic [10:0] pos_inc;
    event_t      ev;

    assign cfg_ready = 1'b1;
    assign s_ready   = !q_status.full;
    assign accept    = s_valid && s_ready;
    assign hdr_last  = (pos_reg == HDR_LAST_POS);
    assign chk_ok    = (~xor_reg == s_in_byte);
    assign pos_inc   = pos_reg + 11'd1;

    // next phase
    always_comb begin
        phase_next = phase_reg;
        if (accept) begin
            case (phase_reg)
                PH_HUNT: begin
                    if (s_in_byte == start_reg) phase_next = PH_HEADER;
                end
                PH_HEADER: begin
                    if (hdr_last) begin
                        if (!chk_ok || len_reg > MAX_PAYLOAD_LEN) begin
                            phase_next = PH_HUNT;
                        end else if (len_reg == 16'd0) begin
                            phase_next = PH_CHECK;
                        end else begin
                            phase_next = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    if ({5'd0, pos_inc} >= len_reg) phase_next = PH_CHECK;
                end
                PH_CHECK: phase_next = PH_HUNT;
                default:  phase_next = PH_HUNT;
            endcase
        end
    end

    // datapath and classification
    always_comb begin
        pos_next  = pos_reg;
        xor_next  = xor_reg;
        id_next   = id_reg;
        len_next  = len_reg;
        type_next = type_reg;
        ev        = EV_DROP;
        push_item.pbyte = 8'd0;
        push_item.pidx  = 10'd0;
        case (phase_reg)
            PH_HUNT: begin
                if (s_in_byte == start_reg) begin
                    pos_next = 11'd1;
                    xor_next = s_in_byte;
                    ev       = EV_HEADER;
                end
            end
            PH_HEADER: begin
                if (!hdr_last) begin
                    case (pos_reg[2:0])
                        3'd1:    id_next   = {s_in_byte, id_reg[7:0]};
                        3'd2:    id_next   = {id_reg[15:8], s_in_byte};
                        3'd3:    len_next  = {s_in_byte, len_reg[7:0]};
                        3'd4:    len_next  = {len_reg[15:8], s_in_byte};
                        3'd5:    type_next = {s_in_byte, type_reg[7:0]};
                        default: type_next = {type_reg[15:8], s_in_byte};
                    endcase
                    xor_next = xor_reg ^ s_in_byte;
                    pos_next = pos_inc;
                    ev       = EV_HEADER;
                end else begin
                    pos_next = 11'd0;
                    xor_next = 8'd0;
                    if (!chk_ok) begin
                        ev = EV_HDR_ERR;
                    end else if (len_reg > MAX_PAYLOAD_LEN) begin
                        ev = EV_OVERSIZE;
                    end else begin
                        ev = EV_HEADER;
                    end
                end
            end
            PH_PAYLOAD: begin
                ev              = EV_PAYLOAD;
                push_item.pbyte = s_in_byte;
                push_item.pidx  = pos_reg[9:0];
                xor_next        = xor_reg ^ s_in_byte;
                pos_next        = pos_inc;
            end
            default: begin
                ev       = chk_ok ? EV_GOOD : EV_DATA_ERR;
                pos_next = 11'd0;
                xor_next = 8'd0;
            end
        endcase
        push_item.ev    = ev;
        push_item.fid   = id_next;
        push_item.ftype = type_next;
        push_item.plen  = len_next[10:0];
    end

    assign push = accept;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
            pos_reg   <= 11'd0;
            xor_reg   <= 8'd0;
            id_reg    <= 16'd0;
            len_reg   <= 16'd0;
            type_reg  <= 16'd0;
            start_reg <= START_BYTE_RESET;
        end else begin
            if (cfg_valid) start_reg <= cfg_data;
            if (accept) begin
                phase_reg <= phase_next;
                pos_reg   <= pos_next;
                xor_reg   <= xor_next;
                id_reg    <= id_next;
                len_reg   <= len_next;
                type_reg  <= type_next;
            end
        end
    end

    `RFD_ASSERT_NEXT(a_hunt_after_error, aclk, aresetn,
        accept && (ev == EV_HDR_ERR || ev == EV_OVERSIZE || ev == EV_DATA_ERR || ev == EV_GOOD),
        phase_reg == PH_HUNT && pos_reg == 11'd0)
    `RFD_ASSERT_IMPL(a_payload_in_range, aclk, aresetn,
        phase_reg == PH_PAYLOAD,
        {5'd0, pos_reg} < len_reg && len_reg <= MAX_PAYLOAD_LEN)

endmodule

@@ design/rfd_fifo.sv @@
// short queue of classified items between parser and result stage
`timescale 1ns / 1ps
`include "radar_frame_deframer_assert.svh"

module rfd_fifo import rfd_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  item_t     push_item,
    input  logic      pop,
    output item_t     pop_item,
    output q_status_t q_status
);

    item_t               mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg;
    logic                do_push;
    logic                do_pop;

    assign q_status.full  = (count_reg == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign q_status.empty = (count_reg == '0);
    assign do_push  = push && !q_status.full;
    assign do_pop   = pop && !q_status.empty;
    assign pop_item = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) mem_reg[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `RFD_ASSERT_IMPL(a_count_bound, aclk, aresetn,
        1'b1, count_reg <= (QUEUE_AW + 1)'(QUEUE_DEPTH))

endmodule

@@ design/rfd_back.sv @@
// result stage: frame counters and the output register
`timescale 1ns / 1ps
`include "radar_frame_deframer_assert.svh"

module rfd_back import rfd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  q_status_t   q_status,
    input  item_t       pop_item,
    output logic        pop,
    output logic        m_valid,
    input  logic        m_ready,
    output item_t       out_item,
    output logic [31:0] good_count,
    output logic [31:0] header_error_count,
    output logic [31:0] data_error_count,
    output logic [31:0] oversize_count
);

    logic        m_valid_reg;
    item_t       item_reg;
    logic [31:0] good_reg, hdr_err_reg, data_err_reg, oversize_reg;

    assign pop = !q_status.empty && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (pop) item_reg <= pop_item;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg  <= 1'b0;
            good_reg     <= 32'd0;
            hdr_err_reg  <= 32'd0;
            data_err_reg <= 32'd0;
            oversize_reg <= 32'd0;
        end else begin
            if (pop) begin
                m_valid_reg <= 1'b1;
                case (pop_item.ev)
                    EV_GOOD:     good_reg     <= good_reg + 32'd1;
                    EV_HDR_ERR:  hdr_err_reg  <= hdr_err_reg + 32'd1;
                    EV_DATA_ERR: data_err_reg <= data_err_reg + 32'd1;
                    EV_OVERSIZE: oversize_reg <= oversize_reg + 32'd1;
                    default:     ;
                endcase
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid            = m_valid_reg;
    assign out_item           = item_reg;
    assign good_count         = good_reg;
    assign header_error_count = hdr_err_reg;
    assign data_error_count   = data_err_reg;
    assign oversize_count     = oversize_reg;

    `RFD_ASSERT_NEXT(a_pop_loads_output, aclk, aresetn, pop, m_valid_reg)
    `RFD_ASSERT_NEXT(a_good_counts, aclk, aresetn,
        pop && pop_item.ev == EV_GOOD, good_reg == $past(good_reg) + 32'd1)

endmodule
